### hdl/rlss_pkg.sv
// Shared types and constants for the RGB LED strip serializer.
package rlss_pkg;

    // Field widths of the stream beats.
    localparam int MODE_W   = 2;
    localparam int SEL_W    = 4;
    localparam int LEVEL_W  = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int WORD_W   = 24;
    localparam int BIT_PTR_W = 5;
    localparam int BITS_PER_LED = 24;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    // Reset values of the timing registers, in tick beats.
    localparam logic [CFG_W-1:0] ONE_HIGH_RST  = 16'd40;
    localparam logic [CFG_W-1:0] ONE_LOW_RST   = 16'd80;
    localparam logic [CFG_W-1:0] ZERO_HIGH_RST = 16'd35;
    localparam logic [CFG_W-1:0] ZERO_LOW_RST  = 16'd50;

    // Kind of an input beat.
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_SET   = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ONE_HIGH  = 2'd0,
        CFG_ONE_LOW   = 2'd1,
        CFG_ZERO_HIGH = 2'd2,
        CFG_ZERO_LOW  = 2'd3
    } cfg_idx_t;

    // Bit timing settings.
    typedef struct packed {
        logic [CFG_W-1:0] one_high;
        logic [CFG_W-1:0] one_low;
        logic [CFG_W-1:0] zero_high;
        logic [CFG_W-1:0] zero_low;
    } cfg_t;

    // Status of the phase engine: current busy flag, next-state view and events.
    typedef struct packed {
        logic busy_now;
        logic busy_next;
        logic high_next;
        logic bit_adv;
        logic led_adv;
        logic done;
    } phase_stat_t;

endpackage

### hdl/rlss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rlss_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/rlss_cfg.sv
// Bit timing configuration registers of the LED strip serializer.
module rlss_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rlss_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [rlss_pkg::CFG_W-1:0]      cfg_data,
    output rlss_pkg::cfg_t                  cfg
);
    import rlss_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index of a write.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_ONE_HIGH:  cfg_next.one_high  = cfg_data;
                CFG_ONE_LOW:   cfg_next.one_low   = cfg_data;
                CFG_ZERO_HIGH: cfg_next.zero_high = cfg_data;
                CFG_ZERO_LOW:  cfg_next.zero_low  = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.one_high  <= ONE_HIGH_RST;
            cfg_reg.one_low   <= ONE_LOW_RST;
            cfg_reg.zero_high <= ZERO_HIGH_RST;
            cfg_reg.zero_low  <= ZERO_LOW_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/rlss_phase.sv
// Phase engine: counts high and low times and walks bits and LEDs of a frame.
module rlss_phase #(
    parameter int NUM_LEDS = 16,
    parameter int TICK_COUNT_WIDTH = 16,
    localparam int LED_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 tick,
    input  logic                 cur_bit,
    input  rlss_pkg::cfg_t       cfg,
    output logic [LED_W-1:0]     led_ptr,
    output rlss_pkg::phase_stat_t stat
);
    import rlss_pkg::*;

    localparam logic [LED_W-1:0] LAST_LED = LED_W'(NUM_LEDS - 1);
    localparam logic [BIT_PTR_W-1:0] LAST_BIT = BIT_PTR_W'(BITS_PER_LED - 1);

    logic                        sending_reg, sending_next;
    logic                        high_reg, high_next;
    logic [LED_W-1:0]            led_reg, led_next;
    logic [BIT_PTR_W-1:0]        bit_reg, bit_next;
    logic [TICK_COUNT_WIDTH-1:0] cnt_reg, cnt_next;

    logic [CFG_W-1:0]            len_sel;
    logic [TICK_COUNT_WIDTH-1:0] len_cut;
    logic [TICK_COUNT_WIDTH-1:0] len;
    logic [TICK_COUNT_WIDTH-1:0] cnt_inc;

    // Length of the current phase; a zero length counts as one tick.
    always_comb
    begin
        if (high_reg)
        begin
            len_sel = cur_bit ? cfg.one_high : cfg.zero_high;
        end
        else
        begin
            len_sel = cur_bit ? cfg.one_low : cfg.zero_low;
        end
        len_cut = TICK_COUNT_WIDTH'({16'd0, len_sel});
        len = (len_cut == '0) ? TICK_COUNT_WIDTH'(1) : len_cut;
        cnt_inc = cnt_reg + TICK_COUNT_WIDTH'(1);
    end

    // Next state of the frame walk.
    always_comb
    begin
        sending_next = sending_reg;
        high_next    = high_reg;
        led_next     = led_reg;
        bit_next     = bit_reg;
        cnt_next     = cnt_reg;
        stat.bit_adv = 1'b0;
        stat.led_adv = 1'b0;
        stat.done    = 1'b0;
        if (start)
        begin
            sending_next = 1'b1;
            high_next    = 1'b1;
            led_next     = '0;
            bit_next     = '0;
            cnt_next     = '0;
        end
        else if (tick && sending_reg)
        begin
            if (cnt_inc < len)
            begin
                cnt_next = cnt_inc;
            end
            else
            begin
                cnt_next = '0;
                if (high_reg)
                begin
                    high_next = 1'b0;
                end
                else if (bit_reg != LAST_BIT)
                begin
                    bit_next     = bit_reg + BIT_PTR_W'(1);
                    high_next    = 1'b1;
                    stat.bit_adv = 1'b1;
                end
                else if (led_reg != LAST_LED)
                begin
                    bit_next     = '0;
                    led_next     = led_reg + LED_W'(1);
                    high_next    = 1'b1;
                    stat.led_adv = 1'b1;
                end
                else
                begin
                    bit_next     = '0;
                    led_next     = '0;
                    sending_next = 1'b0;
                    high_next    = 1'b0;
                    stat.done    = 1'b1;
                end
            end
        end
        stat.busy_now  = sending_reg;
        stat.busy_next = sending_next;
        stat.high_next = high_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg <= 1'b0;
            high_reg    <= 1'b0;
            led_reg     <= '0;
            bit_reg     <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            sending_reg <= sending_next;
            high_reg    <= high_next;
            led_reg     <= led_next;
            bit_reg     <= bit_next;
            cnt_reg     <= cnt_next;
        end
    end

    assign led_ptr = led_reg;

endmodule

### hdl/rgb_led_strip_serializer.sv
// Top level of the RGB LED strip serializer: stream ports, frame buffer and result register.
// Every accepted input beat yields one result beat in the following cycle.
// Throughput: one beat per cycle unless m_tready stalls; phase engine and buffer update in one pass.
// After reset the frame buffer is zeroed by a sweep over every entry with s_tready low.
// A clear beat zeroes the buffer entry by entry while its frame goes out; reads show zero meanwhile.
// Reset is asynchronous and active low; timing registers return to 40, 80, 35 and 50 ticks.
module rgb_led_strip_serializer #(
    parameter int NUM_LEDS = 16,
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input beat stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rlss_pkg::S_TDATA_W-1:0]  s_tdata,  // led_select, red_level, green_level, blue_level
    input  logic [rlss_pkg::MODE_W-1:0]     s_tuser,  // mode
    // Result beat stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rlss_pkg::M_TDATA_W-1:0]  m_tdata,  // pin_level, busy_res, refused
    output logic                            m_tlast,  // frame_done
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [rlss_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [rlss_pkg::CFG_W-1:0]      cfg_data
);
    import rlss_pkg::*;

    localparam int LED_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int SWEEP_W = $clog2(NUM_LEDS + 1);
    localparam logic [LED_W-1:0] LAST_LED = LED_W'(NUM_LEDS - 1);
    localparam logic [SWEEP_W-1:0] SWEEP_END = SWEEP_W'(NUM_LEDS);

    cfg_t        cfg;
    phase_stat_t stat;
    logic [LED_W-1:0] led_ptr;

    logic             accept;
    logic             tick;
    logic             request;
    logic             start;
    logic             refuse;
    logic [SEL_W-1:0] sel;
    logic [WORD_W-1:0] new_word;
    logic             sel_in_range;

    logic [WORD_W-1:0] word_reg, word_next;
    logic              clear_mode_reg, clear_mode_next;
    logic [SWEEP_W-1:0] sweep_cnt_reg;
    logic              sweep_done_reg;

    logic              ram_we;
    logic [LED_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [LED_W-1:0]  ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic              m_tvalid_reg;
    logic [2:0]        m_flags_reg;
    logic              m_last_reg;

    // Input side takes a beat once the reset sweep is done and the result register is free or draining.
    assign s_tready = sweep_done_reg && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign sel      = s_tdata[SEL_W-1:0];
    assign new_word = {s_tdata[19:12], s_tdata[11:4], s_tdata[27:20]};
    assign sel_in_range = {{(32 - SEL_W){1'b0}}, sel} < 32'(NUM_LEDS);

    // Decode the kind of beat.
    always_comb
    begin
        tick    = 1'b0;
        request = 1'b0;
        case (mode_t'(s_tuser))
            MODE_TICK:  tick    = accept;
            MODE_SET:   request = accept;
            MODE_CLEAR: request = accept;
            default:
            begin
                tick    = 1'b0;
                request = 1'b0;
            end
        endcase
        start  = request && !stat.busy_now;
        refuse = request && stat.busy_now;
    end

    rlss_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    rlss_phase #(
        .NUM_LEDS         (NUM_LEDS),
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_phase (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .tick    (tick),
        .cur_bit (word_reg[WORD_W-1]),
        .cfg     (cfg),
        .led_ptr (led_ptr),
        .stat    (stat)
    );

    // Frame buffer writes: reset sweep, a set beat, or zeroing behind a clear frame.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = led_ptr;
        ram_wdata = '0;
        if (!sweep_done_reg)
        begin
            ram_we    = (sweep_cnt_reg != SWEEP_END);
            ram_waddr = LED_W'(sweep_cnt_reg);
        end
        else if (start && (mode_t'(s_tuser) == MODE_SET))
        begin
            ram_we    = sel_in_range;
            ram_waddr = LED_W'(sel);
            ram_wdata = new_word;
        end
        else if (clear_mode_reg && stat.busy_now)
        begin
            ram_we    = 1'b1;
            ram_waddr = led_ptr;
        end
        // While sending, prefetch the next LED; while idle, keep LED 0 ready.
        if (stat.busy_now)
        begin
            ram_raddr = (led_ptr == LAST_LED) ? '0 : led_ptr + LED_W'(1);
        end
        else
        begin
            ram_raddr = '0;
        end
    end

    rlss_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_LEDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shift register holding the word of the LED being sent, current bit on top.
    always_comb
    begin
        word_next       = word_reg;
        clear_mode_next = clear_mode_reg;
        if (start)
        begin
            if (mode_t'(s_tuser) == MODE_CLEAR)
            begin
                clear_mode_next = 1'b1;
                word_next       = '0;
            end
            else
            begin
                clear_mode_next = 1'b0;
                word_next       = (sel == '0) ? new_word : ram_rdata;
            end
        end
        else if (stat.led_adv)
        begin
            word_next = clear_mode_reg ? '0 : ram_rdata;
        end
        else if (stat.bit_adv)
        begin
            word_next = {word_reg[WORD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    // Control registers: clear flag, reset sweep and result handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_mode_reg <= 1'b0;
            sweep_cnt_reg  <= '0;
            sweep_done_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            clear_mode_reg <= clear_mode_next;
            if (!sweep_done_reg)
            begin
                if (sweep_cnt_reg == SWEEP_END)
                begin
                    sweep_done_reg <= 1'b1;
                end
                else
                begin
                    sweep_cnt_reg <= sweep_cnt_reg + SWEEP_W'(1);
                end
            end
            if (accept)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload of each beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_flags_reg <= {refuse, stat.busy_next, stat.busy_next && stat.high_next};
            m_last_reg  <= stat.done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - 3){1'b0}}, m_flags_reg};
    assign m_tlast  = m_last_reg;

endmodule

### hdl/rlss_checker.sv
// Port-level checks on the result stream of the LED strip serializer.
module rlss_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rlss_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tlast
);

    // A stalled result beat stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // The beat that ends a frame shows the line idle and low, with no refusal.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> !m_tdata[1] && !m_tdata[0] && !m_tdata[2])
        else $error("frame end reported while still busy");

    // The pin is only driven high inside a frame.
    a_pin_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[1])
        else $error("pin high while not busy");

    // A request is only refused while a frame is going out.
    a_refuse_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> m_tdata[1])
        else $error("request refused while idle");

endmodule

bind rgb_led_strip_serializer rlss_checker u_rlss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
